### src/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants for the tilt sensor fusion block
// widths, register map, reset values, sequencer codes and saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package tsf_pkg;

  // field widths
  localparam int SMP_W    = 16;
  localparam int SUM_W    = 19;
  localparam int ANG_W    = 32;
  localparam int SCALE_W  = 32;
  localparam int GAIN_W   = 24;
  localparam int STEP_W   = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // group of samples per result
  localparam int GROUP_LEN = 8;
  localparam int CNT_W     = $clog2(GROUP_LEN);

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // width of the values handed to the saturation helper
  localparam int SAT_W = 52;

  // divide by six: x * ceil(2^21 / 6) >> 21, exact for x below 2^19
  localparam int RECIP_SHIFT = 21;
  localparam logic [MUL_B_W-1:0] RECIP6 = 25'd349526;

  // register reset values
  localparam logic [SMP_W-1:0]   ACCEL_ZERO_RST  = 16'd30567;
  localparam logic [SMP_W-1:0]   GYRO_ZERO_RST   = 16'd29584;
  localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 32'd98311;
  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 32'd352322;
  localparam logic [GAIN_W-1:0]  FUSION_GAIN_RST = 24'd65536;
  localparam logic [STEP_W-1:0]  TIME_STEP_RST   = 24'd83886;

  // saturation limits of a signed q16.16 word
  localparam logic signed [SAT_W-1:0] Q_MAX = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SAT_W-1:0] Q_MIN = {{(SAT_W-31){1'b1}}, 31'd0};

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_ZERO  = 3'd0,
    REG_GYRO_ZERO   = 3'd1,
    REG_ACCEL_SCALE = 3'd2,
    REG_GYRO_SCALE  = 3'd3,
    REG_FUSION_GAIN = 3'd4,
    REG_TIME_STEP   = 3'd5
  } tsf_reg_t;

  // configuration register set
  typedef struct packed {
    logic [SMP_W-1:0]   accel_zero;
    logic [SMP_W-1:0]   gyro_zero;
    logic [SCALE_W-1:0] accel_scale;
    logic [SCALE_W-1:0] gyro_scale;
    logic [GAIN_W-1:0]  fusion_gain;
    logic [STEP_W-1:0]  time_step;
  } tsf_cfg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVA,
    ST_DIVG,
    ST_ACC,
    ST_GYR,
    ST_CORR,
    ST_INTG,
    ST_HI,
    ST_LO,
    ST_FUSE,
    ST_OUT
  } tsf_state_t;

  // multiplier step issued to the datapath
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIVA,
    OP_DIVG,
    OP_ACC,
    OP_GYR,
    OP_CORR,
    OP_INTG,
    OP_HI,
    OP_LO
  } tsf_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    first;
    tsf_op_t op;
    logic    out_load;
  } tsf_cmd_t;

  // clamp to the signed 32-bit range
  function automatic logic [ANG_W-1:0] sat_q16(input logic signed [SAT_W-1:0] x);
    logic [ANG_W-1:0] r;
    if (x > Q_MAX) begin
      r = Q_MAX[ANG_W-1:0];
    end else if (x < Q_MIN) begin
      r = Q_MIN[ANG_W-1:0];
    end else begin
      r = x[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tilt_sensor_trimmed_mean_fusion.sv
// ----------------------------------------------------------------------------
// tilt_sensor_trimmed_mean_fusion: tilt angle from accelerometer and gyro
// trimmed-mean filtering of sample groups and complementary angle fusion
// ----------------------------------------------------------------------------
// Sample pairs are taken in groups of eight, one pair per cycle; the first
// seven pairs of a group produce no output word. The eighth pair starts a
// sequence through one shared signed multiplier (two divides by six, the
// two scalings, the fusion correction and three time-step products), then
// the result is placed in the output register once that register is free,
// that is, when the previous word has been taken or none is pending.
// in_ready is low during the sequence.
// Angles are signed q16.16 degrees and saturate at the 32-bit limits.
// Configuration registers should be written only while the block is idle.
`default_nettype none

module tilt_sensor_trimmed_mean_fusion
  import tsf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // input words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SMP_W-1:0]        in_accel_sample,
  input  logic [SMP_W-1:0]        in_gyro_sample,
  // output words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SMP_W-1:0]        out_accel_mean,
  output logic [SMP_W-1:0]        out_gyro_mean,
  output logic signed [ANG_W-1:0] out_accel_angle,
  output logic signed [ANG_W-1:0] out_gyro_rate,
  output logic signed [ANG_W-1:0] out_fused_angle,
  output logic signed [ANG_W-1:0] out_gyro_only_angle,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  tsf_cfg_t cfg;
  tsf_cmd_t cmd;

  // configuration registers
  tsf_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer
  tsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath
  tsf_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg                 (cfg),
    .in_accel_sample     (in_accel_sample),
    .in_gyro_sample      (in_gyro_sample),
    .out_accel_mean      (out_accel_mean),
    .out_gyro_mean       (out_gyro_mean),
    .out_accel_angle     (out_accel_angle),
    .out_gyro_rate       (out_gyro_rate),
    .out_fused_angle     (out_fused_angle),
    .out_gyro_only_angle (out_gyro_only_angle)
  );

endmodule

`default_nettype wire

### src/tsf_regs.sv
// ----------------------------------------------------------------------------
// tsf_regs: configuration registers
// write-only register file, out-of-range indexes are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_regs
  import tsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output tsf_cfg_t             cfg
);

  tsf_cfg_t cfg_r;
  tsf_cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_ZERO:  cfg_nxt.accel_zero  = cfg_wdata[SMP_W-1:0];
        REG_GYRO_ZERO:   cfg_nxt.gyro_zero   = cfg_wdata[SMP_W-1:0];
        REG_ACCEL_SCALE: cfg_nxt.accel_scale = cfg_wdata[SCALE_W-1:0];
        REG_GYRO_SCALE:  cfg_nxt.gyro_scale  = cfg_wdata[SCALE_W-1:0];
        REG_FUSION_GAIN: cfg_nxt.fusion_gain = cfg_wdata[GAIN_W-1:0];
        REG_TIME_STEP:   cfg_nxt.time_step   = cfg_wdata[STEP_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_zero  <= ACCEL_ZERO_RST;
      cfg_r.gyro_zero   <= GYRO_ZERO_RST;
      cfg_r.accel_scale <= ACCEL_SCALE_RST;
      cfg_r.gyro_scale  <= GYRO_SCALE_RST;
      cfg_r.fusion_gain <= FUSION_GAIN_RST;
      cfg_r.time_step   <= TIME_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### src/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl: sequencer for the tilt sensor fusion block
// counts pairs in a group, steps the shared multiplier, owns output valid
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_ctrl
  import tsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tsf_cmd_t cmd
);

  tsf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state, pair count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.take     = 1'b0;
    cmd.first    = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          cmd.first = (cnt_r == '0);
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(GROUP_LEN - 1)) begin
            state_nxt = ST_DIVA;
          end
        end
      end
      ST_DIVA: begin
        cmd.op    = OP_DIVA;
        state_nxt = ST_DIVG;
      end
      ST_DIVG: begin
        cmd.op    = OP_DIVG;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = ST_GYR;
      end
      ST_GYR: begin
        cmd.op    = OP_GYR;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        cmd.op    = OP_CORR;
        state_nxt = ST_INTG;
      end
      ST_INTG: begin
        cmd.op    = OP_INTG;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        cmd.op    = OP_HI;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        cmd.op    = OP_LO;
        state_nxt = ST_FUSE;
      end
      ST_FUSE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output word handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### src/tsf_dpath.sv
// ----------------------------------------------------------------------------
// tsf_dpath: datapath of the tilt sensor fusion block
// group statistics, one shared signed multiplier, angle state, output word
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_dpath
  import tsf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsf_cmd_t                cmd,
  input  tsf_cfg_t                cfg,
  input  logic [SMP_W-1:0]        in_accel_sample,
  input  logic [SMP_W-1:0]        in_gyro_sample,
  output logic [SMP_W-1:0]        out_accel_mean,
  output logic [SMP_W-1:0]        out_gyro_mean,
  output logic signed [ANG_W-1:0] out_accel_angle,
  output logic signed [ANG_W-1:0] out_gyro_rate,
  output logic signed [ANG_W-1:0] out_fused_angle,
  output logic signed [ANG_W-1:0] out_gyro_only_angle
);

  // group statistics
  logic [SUM_W-1:0] a_sum_r, g_sum_r;
  logic [SMP_W-1:0] a_max_r, a_min_r, g_max_r, g_min_r;

  // sequence intermediates
  tsf_op_t              op_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SMP_W-1:0]     am_r, gm_r;
  logic [ANG_W-1:0]     acc_ang_r, gy_rate_r;
  logic [42:0]          b_r;
  logic [43:0]          hip_r;

  // angle state
  logic [ANG_W-1:0]     filt_r, integ_r;

  // output word
  logic [SMP_W-1:0]     o_am_r, o_gm_r;
  logic [ANG_W-1:0]     o_acc_r, o_rate_r, o_filt_r, o_integ_r;

  // multiplier operands and combinational helpers
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [SUM_W-1:0]          a_trim, g_trim;
  logic [SMP_W:0]            a_diff, g_diff;
  logic [ANG_W:0]            c_diff;
  logic [35:0]               integ_sum;
  logic [45:0]               filt_sum;

  // sum without the extremes
  assign a_trim = a_sum_r - {{(SUM_W-SMP_W){1'b0}}, a_max_r}
                          - {{(SUM_W-SMP_W){1'b0}}, a_min_r};
  assign g_trim = g_sum_r - {{(SUM_W-SMP_W){1'b0}}, g_max_r}
                          - {{(SUM_W-SMP_W){1'b0}}, g_min_r};

  // offsets from zero and angle error
  assign a_diff = {1'b0, cfg.accel_zero} - {1'b0, am_r};
  assign g_diff = {1'b0, gm_r} - {1'b0, cfg.gyro_zero};
  assign c_diff = {acc_ang_r[ANG_W-1], acc_ang_r} - {filt_r[ANG_W-1], filt_r};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DIVA: begin
        mul_a = {{(MUL_A_W-SUM_W){1'b0}}, a_trim};
        mul_b = RECIP6;
      end
      OP_DIVG: begin
        mul_a = {{(MUL_A_W-SUM_W){1'b0}}, g_trim};
        mul_b = RECIP6;
      end
      OP_ACC: begin
        mul_a = {{(MUL_A_W-SCALE_W){1'b0}}, cfg.accel_scale};
        mul_b = {{(MUL_B_W-SMP_W-1){a_diff[SMP_W]}}, a_diff};
      end
      OP_GYR: begin
        mul_a = {{(MUL_A_W-SCALE_W){1'b0}}, cfg.gyro_scale};
        mul_b = {{(MUL_B_W-SMP_W-1){g_diff[SMP_W]}}, g_diff};
      end
      OP_CORR: begin
        mul_a = {c_diff[ANG_W], c_diff};
        mul_b = {1'b0, cfg.fusion_gain};
      end
      OP_INTG: begin
        mul_a = {{(MUL_A_W-ANG_W){gy_rate_r[ANG_W-1]}}, gy_rate_r};
        mul_b = {1'b0, cfg.time_step};
      end
      OP_HI: begin
        mul_a = {{(MUL_A_W-19){b_r[42]}}, b_r[42:24]};
        mul_b = {1'b0, cfg.time_step};
      end
      OP_LO: begin
        mul_a = {{(MUL_A_W-24){1'b0}}, b_r[23:0]};
        mul_b = {1'b0, cfg.time_step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // angle updates from the registered product
  assign integ_sum = {prod_r[PROD_W-1], prod_r[PROD_W-1:24]}
                   + {{4{integ_r[ANG_W-1]}}, integ_r};
  assign filt_sum  = {{14{filt_r[ANG_W-1]}}, filt_r}
                   + {{2{hip_r[43]}}, hip_r}
                   + {22'd0, prod_r[47:24]};

  // product register and the step it belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_NONE;
    end else begin
      op_r <= cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // group statistics, first pair of a group loads directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_sum_r <= '0;
      a_max_r <= '0;
      a_min_r <= '0;
      g_sum_r <= '0;
      g_max_r <= '0;
      g_min_r <= '0;
    end else if (cmd.take) begin
      if (cmd.first) begin
        a_sum_r <= {{(SUM_W-SMP_W){1'b0}}, in_accel_sample};
        a_max_r <= in_accel_sample;
        a_min_r <= in_accel_sample;
        g_sum_r <= {{(SUM_W-SMP_W){1'b0}}, in_gyro_sample};
        g_max_r <= in_gyro_sample;
        g_min_r <= in_gyro_sample;
      end else begin
        a_sum_r <= a_sum_r + {{(SUM_W-SMP_W){1'b0}}, in_accel_sample};
        g_sum_r <= g_sum_r + {{(SUM_W-SMP_W){1'b0}}, in_gyro_sample};
        if (in_accel_sample > a_max_r) begin
          a_max_r <= in_accel_sample;
        end else if (in_accel_sample < a_min_r) begin
          a_min_r <= in_accel_sample;
        end
        if (in_gyro_sample > g_max_r) begin
          g_max_r <= in_gyro_sample;
        end else if (in_gyro_sample < g_min_r) begin
          g_min_r <= in_gyro_sample;
        end
      end
    end
  end

  // capture products by the step that made them; the OP_INTG and OP_LO products update the angle state below
  always_ff @(posedge clk) begin
    case (op_r)
      OP_DIVA: am_r      <= prod_r[RECIP_SHIFT +: SMP_W];
      OP_DIVG: gm_r      <= prod_r[RECIP_SHIFT +: SMP_W];
      OP_ACC:  acc_ang_r <= sat_q16({prod_r[PROD_W-1], prod_r[PROD_W-1:8]});
      OP_GYR:  gy_rate_r <= sat_q16({prod_r[PROD_W-1], prod_r[PROD_W-1:8]});
      OP_CORR: b_r       <= prod_r[PROD_W-1:16] + {{11{gy_rate_r[ANG_W-1]}}, gy_rate_r};
      OP_HI:   hip_r     <= prod_r[43:0];
      default: b_r       <= b_r;
    endcase
  end

  // angle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      integ_r <= '0;
    end else begin
      if (op_r == OP_INTG) begin
        integ_r <= sat_q16({{16{integ_sum[35]}}, integ_sum});
      end
      if (op_r == OP_LO) begin
        filt_r <= sat_q16({{6{filt_sum[45]}}, filt_sum});
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_am_r    <= am_r;
      o_gm_r    <= gm_r;
      o_acc_r   <= acc_ang_r;
      o_rate_r  <= gy_rate_r;
      o_filt_r  <= filt_r;
      o_integ_r <= integ_r;
    end
  end

  assign out_accel_mean      = o_am_r;
  assign out_gyro_mean       = o_gm_r;
  assign out_accel_angle     = o_acc_r;
  assign out_gyro_rate       = o_rate_r;
  assign out_fused_angle     = o_filt_r;
  assign out_gyro_only_angle = o_integ_r;

endmodule

`default_nettype wire
